FILE: rtl/fea_pkg.sv
// Shared widths, character codes and the command word passed from parser to arithmetic.
package fea_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAG_W       = VALUE_WIDTH - 1;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int CNT_W       = $clog2(SUM_W);
    localparam int CHAR_W      = 8;
    localparam int OUT_NUM_W   = 32;
    localparam int OUT_DEN_W   = 31;
    localparam int QUEUE_DEPTH = 4;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);

    localparam logic [MAG_W-1:0] MAXV = {MAG_W{1'b1}};

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic             fold;
        logic             emit;
        logic             term_neg;
        logic [MAG_W-1:0] term_num;
        logic [MAG_W-1:0] term_den;
        logic             malformed;
        logic             overflow;
    } cmd_t;

endpackage

FILE: rtl/fea_if.sv
// Character input and result output channel interfaces.
interface fea_in_if;
    logic                      valid;
    logic                      ready;
    logic [fea_pkg::CHAR_W-1:0] char_code;
    logic                      is_last;
    modport source (output valid, char_code, is_last, input ready);
    modport sink (input valid, char_code, is_last, output ready);
endinterface

interface fea_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fea_pkg::OUT_NUM_W-1:0] sum_numerator;
    logic [fea_pkg::OUT_DEN_W-1:0]        sum_denominator;
    logic                                overflow;
    logic                                malformed;
    modport source (output valid, sum_numerator, sum_denominator, overflow, malformed,
                    input ready);
    modport sink (input valid, sum_numerator, sum_denominator, overflow, malformed,
                  output ready);
endinterface

FILE: rtl/fea_front.sv
// Character parser: builds fraction terms and issues fold / emit commands.
module fea_front (
    input  logic          clk,
    input  logic          rst_n,
    fea_in_if.sink        char_in,
    output fea_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_ready
);
    import fea_pkg::*;

    typedef enum logic [1:0] {PH_START, PH_SIGN, PH_NUM, PH_DEN} phase_t;

    phase_t           phase_reg, phase_next;
    logic [MAG_W-1:0] num_reg, num_next;
    logic [MAG_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic             mal_reg, mal_next;
    logic             ovf_reg, ovf_next;
    logic             accept;
    logic             is_digit;
    logic [3:0]       digit;
    logic [MAG_W:0]   added;
    logic [MAG_W-1:0] add_src;
    logic             fold;
    logic [MAG_W-1:0] f_num, f_den;
    logic             f_neg;

    function automatic logic [MAG_W:0] add_digit(logic [MAG_W-1:0] v, logic [3:0] d);
        logic [MAG_W+3:0] w;
        begin
            w = ((MAG_W+4)'(v) << 3) + ((MAG_W+4)'(v) << 1) + (MAG_W+4)'(d);
            if (w > (MAG_W+4)'(MAXV))
                add_digit = {1'b1, MAXV};
            else
                add_digit = {1'b0, w[MAG_W-1:0]};
        end
    endfunction

    assign char_in.ready = cmd_ready;
    assign accept        = char_in.valid && cmd_ready;
    assign is_digit      = char_in.char_code inside {[CH_ZERO:CH_NINE]};
    assign digit         = 4'(char_in.char_code - CH_ZERO);
    assign add_src       = (phase_reg == PH_DEN) ? den_reg : num_reg;
    assign added         = add_digit(add_src, digit);

    always_comb
    begin
        phase_next = phase_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        mal_next   = mal_reg;
        ovf_next   = ovf_reg;
        fold       = 1'b0;
        f_num      = num_reg;
        f_den      = den_reg;
        f_neg      = neg_reg;
        if (is_digit)
        begin
            ovf_next = ovf_reg | added[MAG_W];
            if (phase_reg == PH_DEN)
                den_next = added[MAG_W-1:0];
            else
            begin
                phase_next = PH_NUM;
                num_next   = added[MAG_W-1:0];
            end
        end
        else if (char_in.char_code == CH_SLASH && phase_reg == PH_NUM)
            phase_next = PH_DEN;
        else if (char_in.char_code == CH_PLUS || char_in.char_code == CH_MINUS)
        begin
            if (phase_reg == PH_DEN)
            begin
                if (den_reg == '0)
                    mal_next = 1'b1;
                else
                    fold = 1'b1;
            end
            else if (phase_reg != PH_START)
                mal_next = 1'b1;
            num_next   = '0;
            den_next   = '0;
            neg_next   = (char_in.char_code == CH_MINUS);
            phase_next = PH_SIGN;
        end
        else
        begin
            mal_next   = 1'b1;
            num_next   = '0;
            den_next   = '0;
            neg_next   = 1'b0;
            phase_next = PH_START;
        end
        if (char_in.is_last)
        begin
            if (phase_next == PH_DEN)
            begin
                if (den_next == '0)
                    mal_next = 1'b1;
                else
                begin
                    fold  = 1'b1;
                    f_num = num_next;
                    f_den = den_next;
                    f_neg = neg_next;
                end
            end
            else if (phase_next != PH_START)
                mal_next = 1'b1;
        end
    end

    assign cmd_valid     = accept && (fold || char_in.is_last);
    assign cmd.fold      = fold;
    assign cmd.emit      = char_in.is_last;
    assign cmd.term_neg  = f_neg;
    assign cmd.term_num  = f_num;
    assign cmd.term_den  = f_den;
    assign cmd.malformed = mal_next;
    assign cmd.overflow  = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            num_reg   <= '0;
            den_reg   <= '0;
            neg_reg   <= 1'b0;
            mal_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (char_in.is_last)
            begin
                phase_reg <= PH_START;
                num_reg   <= '0;
                den_reg   <= '0;
                neg_reg   <= 1'b0;
                mal_reg   <= 1'b0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                num_reg   <= num_next;
                den_reg   <= den_next;
                neg_reg   <= neg_next;
                mal_reg   <= mal_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

FILE: rtl/fea_queue.sv
// Small command FIFO between parser and arithmetic.
module fea_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  fea_pkg::cmd_t wr_data,
    input  logic          wr_valid,
    output logic          wr_ready,
    output fea_pkg::cmd_t rd_data,
    output logic          rd_valid,
    input  logic          rd_ready
);
    import fea_pkg::*;

    cmd_t            mem [QUEUE_DEPTH];
    logic [QA_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QA_W:0]   count_reg;
    logic            push, pop;

    assign wr_ready = (count_reg != (QA_W+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/fea_div.sv
// Restoring divider, one quotient bit per cycle.
module fea_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [fea_pkg::SUM_W-1:0] dividend,
    input  logic [fea_pkg::SUM_W-1:0] divisor,
    output logic                      busy,
    output logic [fea_pkg::SUM_W-1:0] quotient
);
    import fea_pkg::*;

    logic [SUM_W-1:0] rem_reg, quo_reg, dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [SUM_W:0]   trial;
    logic             fits;

    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign fits     = (trial >= {1'b0, dvs_reg});
    assign busy     = busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(SUM_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? SUM_W'(trial - {1'b0, dvs_reg}) : trial[SUM_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

endmodule

FILE: rtl/fea_back.sv
// Rational accumulator: cross-multiply, add, binary gcd, exact divide, clamp, emit.
module fea_back (
    input  logic          clk,
    input  logic          rst_n,
    input  fea_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    fea_out_if.source     sum_out
);
    import fea_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_ADD, S_GCD, S_DIV, S_DWAIT, S_CLAMP, S_EMIT
    } state_t;

    state_t                  state_reg;
    cmd_t                    cmd_reg;
    logic                    num_neg_reg;
    logic [MAG_W-1:0]        num_mag_reg, den_reg;
    logic                    ovf_reg, pass2_reg, out_valid_reg;
    logic [PROD_W-1:0]       p1_reg, p2_reg;
    logic [SUM_W-1:0]        a_reg, b_reg, u_reg, v_reg, g_reg;
    logic [CNT_W-1:0]        k_reg;
    logic                    neg_reg;
    logic signed [OUT_NUM_W-1:0] onum_reg;
    logic [OUT_DEN_W-1:0]    oden_reg;
    logic                    oovf_reg, omal_reg;

    logic [MAG_W-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]       mul_p;
    logic [SUM_W-1:0]        sum_a, sum_b, add_mag;
    logic                    add_neg;
    logic                    div_start, busy_a, busy_b;
    logic [SUM_W-1:0]        q_a, q_b, cl_a, cl_b;
    logic                    big_a, big_b, reclamp;
    logic                    out_free;
    logic signed [VALUE_WIDTH-1:0] num_s;

    assign cmd_ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || sum_out.ready;

    always_comb
    begin
        case (state_reg)
            S_MUL1:
            begin
                mul_a = num_mag_reg;
                mul_b = cmd_reg.term_den;
            end
            S_MUL2:
            begin
                mul_a = cmd_reg.term_num;
                mul_b = den_reg;
            end
            default:
            begin
                mul_a = den_reg;
                mul_b = cmd_reg.term_den;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign sum_a = SUM_W'(p1_reg);
    assign sum_b = SUM_W'(p2_reg);
    always_comb
    begin
        if (num_neg_reg == cmd_reg.term_neg)
        begin
            add_mag = sum_a + sum_b;
            add_neg = num_neg_reg;
        end
        else if (sum_a >= sum_b)
        begin
            add_mag = sum_a - sum_b;
            add_neg = num_neg_reg;
        end
        else
        begin
            add_mag = sum_b - sum_a;
            add_neg = cmd_reg.term_neg;
        end
    end

    assign div_start = (state_reg == S_DIV);

    fea_div u_div_num (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_reg),
        .divisor  (g_reg),
        .busy     (busy_a),
        .quotient (q_a)
    );

    fea_div u_div_den (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (b_reg),
        .divisor  (g_reg),
        .busy     (busy_b),
        .quotient (q_b)
    );

    assign big_a   = (q_a > SUM_W'(MAXV));
    assign big_b   = (q_b > SUM_W'(MAXV));
    assign cl_a    = big_a ? SUM_W'(MAXV) : q_a;
    assign cl_b    = big_b ? SUM_W'(MAXV) : q_b;
    assign reclamp = !pass2_reg && (big_a || big_b);

    assign num_s = num_neg_reg ? -signed'({1'b0, num_mag_reg}) : signed'({1'b0, num_mag_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            num_neg_reg   <= 1'b0;
            num_mag_reg   <= '0;
            den_reg       <= MAG_W'(1);
            ovf_reg       <= 1'b0;
            pass2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && sum_out.ready && state_reg != S_EMIT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (cmd_valid)
                        state_reg <= cmd.fold ? S_MUL1 : S_EMIT;
                S_MUL1:  state_reg <= S_MUL2;
                S_MUL2:  state_reg <= S_MUL3;
                S_MUL3:  state_reg <= S_ADD;
                S_ADD:
                begin
                    pass2_reg <= 1'b0;
                    state_reg <= S_GCD;
                end
                S_GCD:
                    if (u_reg == '0)
                        state_reg <= S_DIV;
                S_DIV:   state_reg <= S_DWAIT;
                S_DWAIT:
                    if (!busy_a && !busy_b)
                        state_reg <= S_CLAMP;
                S_CLAMP:
                    if (reclamp)
                    begin
                        ovf_reg   <= 1'b1;
                        pass2_reg <= 1'b1;
                        state_reg <= S_GCD;
                    end
                    else
                    begin
                        num_mag_reg <= q_a[MAG_W-1:0];
                        num_neg_reg <= neg_reg && (q_a != '0);
                        den_reg     <= q_b[MAG_W-1:0];
                        state_reg   <= cmd_reg.emit ? S_EMIT : S_IDLE;
                    end
                S_EMIT:
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        num_neg_reg   <= 1'b0;
                        num_mag_reg   <= '0;
                        den_reg       <= MAG_W'(1);
                        ovf_reg       <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (cmd_valid)
                    cmd_reg <= cmd;
            S_MUL1: p1_reg <= mul_p;
            S_MUL2: p2_reg <= mul_p;
            S_MUL3: b_reg  <= SUM_W'(mul_p);
            S_ADD:
            begin
                a_reg   <= add_mag;
                neg_reg <= add_neg;
                u_reg   <= add_mag;
                v_reg   <= b_reg;
                k_reg   <= '0;
            end
            S_GCD:
                if (u_reg == '0)
                    g_reg <= v_reg << k_reg;
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_reg <= u_reg >> 1;
                    v_reg <= v_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end
                else if (!u_reg[0])
                    u_reg <= u_reg >> 1;
                else if (!v_reg[0])
                    v_reg <= v_reg >> 1;
                else if (u_reg >= v_reg)
                    u_reg <= (u_reg - v_reg) >> 1;
                else
                    v_reg <= (v_reg - u_reg) >> 1;
            S_CLAMP:
                if (reclamp)
                begin
                    a_reg <= cl_a;
                    b_reg <= cl_b;
                    u_reg <= cl_a;
                    v_reg <= cl_b;
                    k_reg <= '0;
                end
            S_EMIT:
                if (out_free)
                begin
                    onum_reg <= OUT_NUM_W'(num_s);
                    oden_reg <= OUT_DEN_W'(den_reg);
                    oovf_reg <= ovf_reg | cmd_reg.overflow;
                    omal_reg <= cmd_reg.malformed;
                end
            default: ;
        endcase
    end

    assign sum_out.valid           = out_valid_reg;
    assign sum_out.sum_numerator   = onum_reg;
    assign sum_out.sum_denominator = oden_reg;
    assign sum_out.overflow        = oovf_reg;
    assign sum_out.malformed       = omal_reg;

endmodule

FILE: rtl/fraction_expression_accumulator.sv
// Top level: parser front end, command queue and rational accumulator back end.
//
//   channel   dir  handshake     word
//   char_in   in   valid/ready   char_code[7:0], is_last
//   sum_out   out  valid/ready   sum_numerator[31:0] s, sum_denominator[30:0],
//                                overflow, malformed
//
// A character without a fold or the last mark only updates parser registers;
// char_in is ready while the queue has room. A fold runs three multiplies, an add,
// binary-gcd steps and a divide; an overflowing fold runs gcd and divide again.
// Up to 4 fold/emit commands queue ahead of the accumulator; char_in stalls
// when the queue is full. sum_out is a registered word that may stall freely.
// rst_n clears all control state asynchronously; total restarts at 0/1.
module fraction_expression_accumulator (
    input  logic      clk,
    input  logic      rst_n,
    fea_in_if.sink    char_in,
    fea_out_if.source sum_out
);
    import fea_pkg::*;

    cmd_t q_in_data, q_out_data;
    logic q_in_valid, q_in_ready, q_out_valid, q_out_ready;

    fea_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_in),
        .cmd       (q_in_data),
        .cmd_valid (q_in_valid),
        .cmd_ready (q_in_ready)
    );

    fea_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (q_in_data),
        .wr_valid (q_in_valid),
        .wr_ready (q_in_ready),
        .rd_data  (q_out_data),
        .rd_valid (q_out_valid),
        .rd_ready (q_out_ready)
    );

    fea_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_out_data),
        .cmd_valid (q_out_valid),
        .cmd_ready (q_out_ready),
        .sum_out   (sum_out)
    );

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        sum_out.valid |-> sum_out.sum_denominator != '0)
        else $error("zero denominator on output");

    a_zero_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_out.valid && sum_out.sum_numerator == '0) |-> sum_out.sum_denominator == 31'd1)
        else $error("zero total not reduced to 0/1");

    a_num_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        sum_out.valid |-> sum_out.sum_numerator != 32'sh8000_0000)
        else $error("numerator outside saturated range");

endmodule

FILE: sim/tb_fraction_expression_accumulator.sv
// Testbench for the fraction expression accumulator: directed table, then random expressions and characters.
`timescale 1ns / 100ps

module tb_fraction_expression_accumulator;
    import fea_pkg::*;

    localparam longint MAXL = (64'd1 << (VALUE_WIDTH - 1)) - 1;
    localparam int IDLE_LIMIT = 20000;

    typedef enum logic [1:0] {P_START, P_SIGN, P_NUM, P_DEN} phase_e;

    typedef struct packed {
        logic signed [OUT_NUM_W-1:0] num;
        logic [OUT_DEN_W-1:0]        den;
        logic                        ovf;
        logic                        bad;
    } sum_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       known;
        sum_t       want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fea_in_if  char_in();
    fea_out_if sum_out();

    fraction_expression_accumulator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_in),
        .sum_out (sum_out)
    );

    always #5 clk = ~clk;

    longint acc_num;
    longint acc_den;
    longint frac_num;
    longint frac_den;
    bit     frac_neg;
    phase_e phase;
    bit     ovf_seen;
    bit     bad_seen;

    sum_t   pending_sums[$];
    int     errors = 0;
    int     idle_cycles = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     finishing = 1'b0;

    function automatic longint gcd64(longint a, longint b);
        longint t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic longint push_digit(longint v, longint d);
        if (v > (MAXL - d) / 10)
        begin
            ovf_seen = 1'b1;
            return MAXL;
        end
        return v * 10 + d;
    endfunction

    task automatic clear_sum();
        acc_num = 0;
        acc_den = 1;
        frac_num = 0;
        frac_den = 0;
        frac_neg = 1'b0;
        phase = P_START;
        ovf_seen = 1'b0;
        bad_seen = 1'b0;
    endtask

    task automatic fold_fraction();
        longint n;
        longint d;
        longint mag;
        longint g;
        bit neg;
        bit clamped;
        if (frac_den == 0)
        begin
            bad_seen = 1'b1;
            return;
        end
        n = acc_num * frac_den + (frac_neg ? -frac_num : frac_num) * acc_den;
        d = acc_den * frac_den;
        neg = n < 0;
        mag = neg ? -n : n;
        g = gcd64(mag, d);
        mag = mag / g;
        d = d / g;
        clamped = 1'b0;
        if (mag > MAXL)
        begin
            mag = MAXL;
            clamped = 1'b1;
        end
        if (d > MAXL)
        begin
            d = MAXL;
            clamped = 1'b1;
        end
        if (clamped)
        begin
            ovf_seen = 1'b1;
            g = gcd64(mag, d);
            mag = mag / g;
            d = d / g;
        end
        acc_num = neg ? -mag : mag;
        acc_den = d;
    endtask

    task automatic predict_char(input logic [7:0] ch, input logic last);
        sum_t s;
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            if (phase == P_DEN)
                frac_den = push_digit(frac_den, ch - CH_ZERO);
            else
            begin
                phase = P_NUM;
                frac_num = push_digit(frac_num, ch - CH_ZERO);
            end
        end
        else if (ch == CH_SLASH && phase == P_NUM)
            phase = P_DEN;
        else if (ch == CH_PLUS || ch == CH_MINUS)
        begin
            if (phase == P_DEN)
                fold_fraction();
            else if (phase != P_START)
                bad_seen = 1'b1;
            frac_num = 0;
            frac_den = 0;
            frac_neg = (ch == CH_MINUS);
            phase = P_SIGN;
        end
        else
        begin
            bad_seen = 1'b1;
            frac_num = 0;
            frac_den = 0;
            frac_neg = 1'b0;
            phase = P_START;
        end
        if (last)
        begin
            if (phase == P_DEN)
                fold_fraction();
            else if (phase != P_START)
                bad_seen = 1'b1;
            s.num = acc_num[31:0];
            s.den = acc_den[30:0];
            s.ovf = ovf_seen;
            s.bad = bad_seen;
            pending_sums.push_back(s);
            clear_sum();
        end
    endtask

    task automatic send_char(input logic [7:0] ch, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            char_in.valid <= 1'b0;
            @(posedge clk);
        end
        char_in.valid <= 1'b1;
        char_in.char_code <= ch;
        char_in.is_last <= last;
        @(posedge clk);
        while (!char_in.ready)
            @(posedge clk);
        predict_char(ch, last);
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++)
            send_char(t[i], i == t.len() - 1);
    endtask

    task automatic drain();
        char_in.valid <= 1'b0;
        @(posedge clk);
        while (pending_sums.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_number(input int digits);
        for (int i = 0; i < digits; i++)
            send_char(8'(CH_ZERO + $urandom_range(9)), 1'b0);
    endtask

    task automatic send_random_expr();
        int terms;
        int kind;
        terms = $urandom_range(1, 4);
        for (int t = 0; t < terms; t++)
        begin
            kind = $urandom_range(99);
            if (t > 0 || $urandom_range(1))
                send_char($urandom_range(1) ? CH_MINUS : CH_PLUS, 1'b0);
            send_number(kind < 5 ? $urandom_range(10, 12) : $urandom_range(1, 3));
            if (kind < 90)
            begin
                send_char(CH_SLASH, 1'b0);
                send_number(kind < 8 ? $urandom_range(10, 12) : $urandom_range(1, 3));
            end
            if (kind >= 95)
                send_char(8'($urandom_range(255)), 1'b0);
        end
        send_char($urandom_range(3) == 0 ? 8'(CH_ZERO + $urandom_range(9)) : CH_NINE, 1'b1);
    endtask

    always @(posedge clk)
    begin
        sum_out.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        sum_t got;
        sum_t want;
        if (rst_n && sum_out.valid && sum_out.ready)
        begin
            got = {sum_out.sum_numerator, sum_out.sum_denominator,
                   sum_out.overflow, sum_out.malformed};
            if (pending_sums.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected sum %0d/%0d ovf=%0b bad=%0b",
                             got.num, got.den, got.ovf, got.bad);
            end
            else
            begin
                want = pending_sums.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("sum mismatch: exp %0d/%0d ovf=%0b bad=%0b got %0d/%0d ovf=%0b bad=%0b",
                                 want.num, want.den, want.ovf, want.bad,
                                 got.num, got.den, got.ovf, got.bad);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((char_in.valid && char_in.ready) || (sum_out.valid && sum_out.ready) || finishing)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    row_t table_rows[$];

    task automatic add_row(input logic [7:0] ch, input logic last, input logic known,
                           input sum_t want);
        row_t r;
        r.ch = ch;
        r.last = last;
        r.known = known;
        r.want = want;
        table_rows.push_back(r);
    endtask

    initial
    begin
        int sent;
        int n_before;
        sum_t none;
        none = '0;
        char_in.valid = 1'b0;
        char_in.char_code = '0;
        char_in.is_last = 1'b0;
        clear_sum();

        // single-character expressions, each malformed with total 0/1
        add_row(CH_ZERO, 1'b1, 1'b1, '{32'sd0, 31'd1, 1'b0, 1'b1});
        add_row(CH_PLUS, 1'b1, 1'b1, '{32'sd0, 31'd1, 1'b0, 1'b1});
        add_row(CH_SLASH, 1'b1, 1'b1, '{32'sd0, 31'd1, 1'b0, 1'b1});
        add_row(8'hFF, 1'b1, 1'b1, '{32'sd0, 31'd1, 1'b0, 1'b1});
        add_row(8'h00, 1'b1, 1'b1, '{32'sd0, 31'd1, 1'b0, 1'b1});
        // -1/2+1/3 = -1/6
        add_row(CH_MINUS, 1'b0, 1'b0, none);
        add_row("1", 1'b0, 1'b0, none);
        add_row(CH_SLASH, 1'b0, 1'b0, none);
        add_row("2", 1'b0, 1'b0, none);
        add_row(CH_PLUS, 1'b0, 1'b0, none);
        add_row("1", 1'b0, 1'b0, none);
        add_row(CH_SLASH, 1'b0, 1'b0, none);
        add_row("3", 1'b1, 1'b1, '{-32'sd1, 31'd6, 1'b0, 1'b0});
        // zero denominator
        add_row("5", 1'b0, 1'b0, none);
        add_row(CH_SLASH, 1'b0, 1'b0, none);
        add_row(CH_ZERO, 1'b1, 1'b1, '{32'sd0, 31'd1, 1'b0, 1'b1});
        // sign inside numerator, then 2/4
        add_row("7", 1'b0, 1'b0, none);
        add_row(CH_MINUS, 1'b0, 1'b0, none);
        add_row("2", 1'b0, 1'b0, none);
        add_row(CH_SLASH, 1'b0, 1'b0, none);
        add_row("4", 1'b1, 1'b0, none);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
        begin
            n_before = pending_sums.size();
            send_char(table_rows[i].ch, table_rows[i].last);
            if (table_rows[i].known && pending_sums.size() > n_before)
                pending_sums[$] = table_rows[i].want;
        end
        // saturating literals and fold overflow
        send_text("99999999999/1");
        send_text("-2147483647/1-2147483647/1");
        send_text("1/2147483647+1/2147483646");
        send_text("+1/99999999999");
        send_text("1/3-1/3");
        drain();

        sent = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 52 : 32) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 52 : 32) : 0;
            repeat (16)
                send_random_expr();
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (20)
        begin
            send_char(8'($urandom_range(255)), $urandom_range(3) == 0);
            if ($urandom_range(1))
                send_text("1/1");
        end
        send_char(CH_NINE, 1'b1);

        finishing = 1'b1;
        char_in.valid <= 1'b0;
        fork
            begin
                while (pending_sums.size() != 0)
                    @(posedge clk);
                repeat (400) @(posedge clk);
            end
            begin
                repeat (200000) @(posedge clk);
                errors++;
            end
        join_any
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
